[design/fapm_pkg.sv]
// Shared types and constants for the four-axis PID thruster mixer.
`timescale 1ns / 1ps

package fapm_pkg;

  // Field widths of one input item and one result item.
  localparam int ANGLE_W = 15;
  localparam int DEPTH_W = 16;
  localparam int KEY_W_BITS = 4;
  localparam int CMD_W = 16;
  localparam int GAIN_W = 16;
  localparam int GAINS_W = 48;
  localparam int CFG_IDX_W = 2;

  // Multiplier operand A width: holds the degree-to-radian constant or one gain.
  localparam int MUL_A_W = 26;
  localparam int DEG2RAD_Q30 = 18740330;

  // Key codes.
  localparam logic [KEY_W_BITS-1:0] KEY_FWD   = 4'd0;
  localparam logic [KEY_W_BITS-1:0] KEY_BACK  = 4'd1;
  localparam logic [KEY_W_BITS-1:0] KEY_LEFT  = 4'd2;
  localparam logic [KEY_W_BITS-1:0] KEY_RIGHT = 4'd3;
  localparam logic [KEY_W_BITS-1:0] KEY_SWAYL = 4'd4;
  localparam logic [KEY_W_BITS-1:0] KEY_SWAYR = 4'd5;
  localparam logic [KEY_W_BITS-1:0] KEY_DOWN  = 4'd6;
  localparam logic [KEY_W_BITS-1:0] KEY_UP    = 4'd7;
  localparam logic [KEY_W_BITS-1:0] KEY_STOP  = 4'd8;

  // Item kinds.
  localparam logic KIND_SENSOR = 1'b0;
  localparam logic KIND_KEY    = 1'b1;

  // Axis and base-thrust slots.
  localparam logic [1:0] AX_ROLL  = 2'd0;
  localparam logic [1:0] AX_PITCH = 2'd1;
  localparam logic [1:0] AX_YAW   = 2'd2;
  localparam logic [1:0] AX_DEPTH = 2'd3;
  localparam logic [1:0] TH_LEFT  = 2'd0;
  localparam logic [1:0] TH_RIGHT = 2'd1;
  localparam logic [1:0] TH_SWAY  = 2'd2;
  localparam logic [1:0] TH_HEAVE = 2'd3;

  // Gain selectors within one packed gain register.
  localparam logic [1:0] K_P = 2'd0;
  localparam logic [1:0] K_I = 2'd1;
  localparam logic [1:0] K_D = 2'd2;

  // Base thrust levels.
  localparam logic [10:0] BASE_MID  = 11'd1500;
  localparam logic [10:0] BASE_HIGH = 11'd1600;
  localparam logic [10:0] BASE_LOW  = 11'd1400;
  localparam logic [10:0] BASE_DIVE = 11'd1650;
  localparam logic [DEPTH_W-1:0] DEPTH_TARGET_RST = 16'd13392;

  // Tag that travels with each product through the multiplier.
  typedef struct packed {
    logic       is_rad;
    logic [1:0] ax;
    logic [1:0] k;
  } fapm_tag_t;

endpackage

[design/fapm_if.sv]
// Item channel interfaces: sensor or key items in, thruster commands out.
`timescale 1ns / 1ps

interface fapm_in_if;
  import fapm_pkg::*;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic signed [ANGLE_W-1:0]    roll_angle;
  logic signed [ANGLE_W-1:0]    pitch_angle;
  logic signed [ANGLE_W-1:0]    yaw_angle;
  logic [DEPTH_W-1:0]           depth_reading;
  logic [KEY_W_BITS-1:0]        key_code;
  modport source (output valid, kind, roll_angle, pitch_angle, yaw_angle, depth_reading,
                  key_code, input ready);
  modport sink (input valid, kind, roll_angle, pitch_angle, yaw_angle, depth_reading,
                key_code, output ready);
endinterface

interface fapm_out_if;
  import fapm_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [CMD_W-1:0] thruster_0;
  logic signed [CMD_W-1:0] thruster_1;
  logic signed [CMD_W-1:0] thruster_2;
  logic signed [CMD_W-1:0] thruster_3;
  logic signed [CMD_W-1:0] thruster_4;
  logic signed [CMD_W-1:0] thruster_5;
  modport source (output valid, thruster_0, thruster_1, thruster_2, thruster_3, thruster_4,
                  thruster_5, input ready);
  modport sink (input valid, thruster_0, thruster_1, thruster_2, thruster_3, thruster_4,
                thruster_5, output ready);
endinterface

[design/fapm_mul.sv]
// Shared signed multiplier with a registered product and its tag.
`timescale 1ns / 1ps

module fapm_mul #(
  parameter int AW = 26,
  parameter int BW = 33
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    go,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  input  fapm_pkg::fapm_tag_t     tag,
  output logic signed [AW+BW-1:0] p,
  output logic                    p_valid,
  output fapm_pkg::fapm_tag_t     p_tag
);
  import fapm_pkg::*;

  // Product and tag register; the valid flag is control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= go;
    end
    if (go) begin
      p     <= a * b;
      p_tag <= tag;
    end
  end

endmodule

[design/four_axis_pid_thruster_mixer.sv]
// Top level: four-axis PID sequencer around one shared multiplier, with thruster mixing.
// A sensor item is processed in steps: 14 products (two degree-to-radian conversions, three
// gain products per axis) issue one per cycle through the shared multiplier, then six
// commands are finished one per cycle, and the result is offered once the output is free.
// Key items give no result. No new item is accepted until a sensor item's result is loaded.
// Synchronous active-high reset restores gains to zero, base thrust to 1500 and targets.
`timescale 1ns / 1ps

module four_axis_pid_thruster_mixer #(
  parameter int ANGLE_FRAC_BITS = 6,
  parameter int INTERNAL_FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  fapm_in_if.sink                             in_ch,
  fapm_out_if.source                          out_ch,
  input  logic                                cfg_we,
  input  logic [fapm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fapm_pkg::GAINS_W-1:0]        cfg_data
);
  import fapm_pkg::*;

  localparam int I  = INTERNAL_FRAC_BITS;
  localparam int A  = ANGLE_FRAC_BITS;
  localparam int EW = I + 16;
  localparam int BW = EW + 1;
  localparam int IW = I + 3;
  localparam int FW = I + 46;
  localparam int OF = I + 6;
  localparam int SH = 30 + A - I;
  localparam int PW = MUL_A_W + BW;
  localparam int LIM = (255 * (2 ** I) + 50) / 100;

  localparam logic signed [EW-1:0] HALF_TURN = EW'(180) <<< I;
  localparam logic signed [EW-1:0] FULL_TURN = EW'(360) <<< I;
  localparam logic signed [BW-1:0] LIM_HI = BW'(LIM);
  localparam logic signed [BW-1:0] LIM_LO = -BW'(LIM);
  localparam logic signed [FW-1:0] DB_LIM = FW'(1530) <<< OF;
  localparam logic signed [FW-1:0] DB_ADD = FW'(30) <<< OF;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [4:0] STEP_PITCH = 5'd1;
  localparam logic [4:0] STEP_GAIN0 = 5'd2;
  localparam logic [4:0] STEP_LAST_ISSUE = 5'd13;
  localparam logic [4:0] STEP_FIN0 = 5'd15;
  localparam logic [4:0] STEP_END = 5'd21;

  // Configuration and persistent state.
  logic [GAINS_W-1:0]       gains [4];
  logic signed [IW-1:0]     integral [4];
  logic signed [EW-1:0]     prev_err [4];
  logic [10:0]              base [4];
  logic signed [8:0]        yaw_target;
  logic [DEPTH_W-1:0]       depth_target;
  logic [DEPTH_W-1:0]       last_depth;

  // Per-item working registers.
  logic [1:0]               state;
  logic [4:0]               step;
  logic [1:0]               ax_i;
  logic [1:0]               k_i;
  logic signed [ANGLE_W-1:0] roll_q;
  logic signed [ANGLE_W-1:0] pitch_q;
  logic signed [EW-1:0]     err [4];
  logic signed [FW-1:0]     acc;
  logic signed [FW-1:0]     term [4];
  logic [CMD_W-1:0]         res [6];

  // Multiplier connections.
  logic                     mul_go;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [BW-1:0]     mul_b;
  fapm_tag_t                mul_tag;
  logic signed [PW-1:0]     p;
  logic                     p_valid;
  fapm_tag_t                p_tag;

  // Combinational helpers.
  logic signed [EW-1:0]     yaw_raw;
  logic signed [EW-1:0]     yaw_err;
  logic signed [16:0]       depth_diff;
  logic signed [EW-1:0]     depth_err;
  logic signed [EW-1:0]     err_cur;
  logic signed [BW-1:0]     diff;
  logic signed [BW-1:0]     ssum;
  logic signed [IW-1:0]     s_clamp;
  logic [GAIN_W-1:0]        gain_sel;
  logic signed [ANGLE_W:0]  rad_ang;
  logic [ANGLE_W:0]         rad_mag;
  logic [PW-1:0]            rad_sum;
  logic signed [EW-1:0]     rad_val;
  logic signed [FW-1:0]     p_ext;
  logic signed [FW-1:0]     heave_f;
  logic signed [FW-1:0]     force_sel;
  logic [2:0]               fin_j;
  logic                     issue_gain;
  logic                     in_acc;
  logic                     out_acc;

  fapm_mul #(.AW(MUL_A_W), .BW(BW)) u_mul (
    .clk(clk), .rst(rst), .go(mul_go), .a(mul_a), .b(mul_b), .tag(mul_tag),
    .p(p), .p_valid(p_valid), .p_tag(p_tag)
  );

  // Truncate toward zero after the deadband offset, then saturate to 16 bits.
  function automatic logic [CMD_W-1:0] finish_f(input logic signed [FW-1:0] f);
    logic signed [FW-1:0] f2;
    logic [FW-1:0]        mag;
    logic [FW-1:0]        t;
    logic [CMD_W-1:0]     r;
    if (f >= 0 && f < DB_LIM) f2 = f + DB_ADD;
    else if (f < 0 && f > -DB_LIM) f2 = f - DB_ADD;
    else f2 = f;
    mag = (f2 < 0) ? FW'(-f2) : FW'(f2);
    t = mag >> OF;
    if (f2 >= 0) r = (t > FW'(32767)) ? 16'h7FFF : t[CMD_W-1:0];
    else r = (t > FW'(32768)) ? 16'h8000 : CMD_W'(-t[CMD_W-1:0]);
    return r;
  endfunction

  assign in_ch.ready = (state == ST_IDLE);
  assign in_acc = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;

  // Yaw error wraps once by a full turn; depth error in internal units.
  always_comb begin
    yaw_raw = (EW'(yaw_target) <<< I) - (EW'(in_ch.yaw_angle) <<< (I - A));
    if (yaw_raw > HALF_TURN) yaw_err = yaw_raw - FULL_TURN;
    else if (yaw_raw < -HALF_TURN) yaw_err = yaw_raw + FULL_TURN;
    else yaw_err = yaw_raw;
    depth_diff = $signed({1'b0, depth_target}) - $signed({1'b0, in_ch.depth_reading});
    depth_err = EW'(depth_diff) <<< (I - 4);
  end

  // Issue side: operands for the shared multiplier.
  always_comb begin
    issue_gain = (state == ST_RUN) && (step >= STEP_GAIN0) && (step <= STEP_LAST_ISSUE);
    mul_go = (state == ST_RUN) && (step <= STEP_LAST_ISSUE);
    err_cur = err[ax_i];
    diff = BW'(err_cur) - BW'(prev_err[ax_i]);
    ssum = BW'(err_cur) + BW'(integral[ax_i]);
    if (ssum > LIM_HI) s_clamp = IW'(LIM_HI);
    else if (ssum < LIM_LO) s_clamp = IW'(LIM_LO);
    else s_clamp = IW'(ssum);
    case (k_i)
      K_P: gain_sel = gains[ax_i][15:0];
      K_I: gain_sel = gains[ax_i][31:16];
      default: gain_sel = gains[ax_i][47:32];
    endcase
    rad_ang = (step == STEP_PITCH) ? (ANGLE_W+1)'(pitch_q) : (ANGLE_W+1)'(roll_q);
    rad_mag = (rad_ang < 0) ? (ANGLE_W+1)'(-rad_ang) : (ANGLE_W+1)'(rad_ang);
    if (step < STEP_GAIN0) begin
      mul_a = MUL_A_W'(DEG2RAD_Q30);
      mul_b = BW'(rad_mag);
      mul_tag = '{is_rad: 1'b1, ax: (step == STEP_PITCH) ? AX_PITCH : AX_ROLL, k: K_P};
    end else begin
      mul_a = MUL_A_W'($signed(gain_sel));
      case (k_i)
        K_P: mul_b = BW'(err_cur);
        K_I: mul_b = BW'(s_clamp);
        default: mul_b = diff;
      endcase
      mul_tag = '{is_rad: 1'b0, ax: ax_i, k: k_i};
    end
  end

  // Accumulate side: rounding of radians and the product sum.
  always_comb begin
    rad_sum = PW'(p) + (PW'(1) << (SH - 1));
    rad_val = EW'(rad_sum >> SH);
    p_ext = FW'(p);
  end

  // Force selection for the finishing steps.
  always_comb begin
    fin_j = 3'(step - STEP_FIN0);
    heave_f = $signed(FW'(base[TH_HEAVE])) <<< OF;
    heave_f = heave_f + term[AX_DEPTH];
    case (fin_j)
      3'd0: force_sel = heave_f - term[AX_PITCH] - term[AX_ROLL];
      3'd1: force_sel = heave_f - term[AX_PITCH] + term[AX_ROLL];
      3'd2: force_sel = heave_f + (term[AX_PITCH] <<< 1);
      3'd3: force_sel = ($signed(FW'(base[TH_LEFT])) <<< OF) + term[AX_YAW];
      3'd4: force_sel = ($signed(FW'(base[TH_RIGHT])) <<< OF) - term[AX_YAW];
      3'd5: force_sel = $signed(FW'(base[TH_SWAY])) <<< OF;
      default: force_sel = '0;
    endcase
  end

  // Sequencer, state updates and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step <= '0;
      ax_i <= '0;
      k_i <= '0;
      out_ch.valid <= 1'b0;
      for (int n = 0; n < 4; n++) begin
        gains[n] <= '0;
        integral[n] <= '0;
        prev_err[n] <= '0;
        base[n] <= BASE_MID;
      end
      yaw_target <= '0;
      depth_target <= DEPTH_TARGET_RST;
      last_depth <= '0;
    end else begin
      // A taken result clears the valid flag unless a new one is loaded below.
      if (out_acc && state != ST_DONE) out_ch.valid <= 1'b0;
      if (cfg_we) gains[cfg_index] <= cfg_data;

      case (state)
        ST_IDLE: begin
          if (in_acc && in_ch.kind == KIND_KEY) begin
            case (in_ch.key_code)
              KEY_FWD: begin
                base[TH_LEFT] <= BASE_HIGH;
                base[TH_RIGHT] <= BASE_HIGH;
              end
              KEY_BACK: begin
                base[TH_LEFT] <= BASE_LOW;
                base[TH_RIGHT] <= BASE_LOW;
              end
              KEY_LEFT: yaw_target <= (yaw_target == -9'sd180) ? 9'sd180 : yaw_target - 9'sd1;
              KEY_RIGHT: yaw_target <= (yaw_target == 9'sd180) ? -9'sd180 : yaw_target + 9'sd1;
              KEY_SWAYL: base[TH_SWAY] <= BASE_LOW;
              KEY_SWAYR: base[TH_SWAY] <= BASE_HIGH;
              KEY_DOWN: begin
                base[TH_HEAVE] <= BASE_DIVE;
                depth_target <= last_depth;
              end
              KEY_UP: begin
                base[TH_HEAVE] <= BASE_MID;
                depth_target <= last_depth;
              end
              KEY_STOP: begin
                base[TH_LEFT] <= BASE_MID;
                base[TH_RIGHT] <= BASE_MID;
                base[TH_SWAY] <= BASE_MID;
              end
              default: ;
            endcase
          end else if (in_acc) begin
            roll_q <= in_ch.roll_angle;
            pitch_q <= in_ch.pitch_angle;
            err[AX_YAW] <= yaw_err;
            err[AX_DEPTH] <= depth_err;
            last_depth <= in_ch.depth_reading;
            step <= '0;
            ax_i <= AX_ROLL;
            k_i <= K_P;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          step <= step + 5'd1;
          if (step == STEP_END - 5'd1) state <= ST_DONE;
          // Integral and previous error update as their products issue.
          if (issue_gain) begin
            if (k_i == K_I) integral[ax_i] <= s_clamp;
            if (k_i == K_D) begin
              prev_err[ax_i] <= err_cur;
              k_i <= K_P;
              ax_i <= ax_i + 2'd1;
            end else begin
              k_i <= k_i + 2'd1;
            end
          end
          if (p_valid) begin
            if (p_tag.is_rad) begin
              err[p_tag.ax] <= ((p_tag.ax == AX_PITCH) ? (pitch_q < 0) : (roll_q < 0)) ?
                               rad_val : -rad_val;
            end else if (p_tag.k == K_P) begin
              acc <= p_ext;
            end else if (p_tag.k == K_I) begin
              acc <= acc + p_ext;
            end else begin
              term[p_tag.ax] <= acc + p_ext;
            end
          end
          if (step >= STEP_FIN0) res[fin_j] <= finish_f(force_sel);
        end
        ST_DONE: begin
          if (!out_ch.valid || out_ch.ready) begin
            out_ch.valid <= 1'b1;
            out_ch.thruster_0 <= res[0];
            out_ch.thruster_1 <= res[1];
            out_ch.thruster_2 <= res[2];
            out_ch.thruster_3 <= res[3];
            out_ch.thruster_4 <= res[4];
            out_ch.thruster_5 <= res[5];
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

[design/fapm_chk.sv]
// Port-level checker for the thruster mixer, bound to the top level.
`timescale 1ns / 1ps

module fapm_chk (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_kind,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] out_t0
);
  import fapm_pkg::*;

  // A result waiting to be taken stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_t0))
    else $error("result changed while stalled");

  // Reset leaves no result pending.
  a_rst_clear: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result pending after reset");

  // A key item produces no result.
  a_key_silent: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind == KIND_KEY && !out_valid |=> !out_valid)
    else $error("key item produced a result");

  // A sensor item occupies the block.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_kind == KIND_SENSOR |=> !in_ready)
    else $error("new item taken while a sensor item runs");

endmodule

bind four_axis_pid_thruster_mixer fapm_chk u_fapm_chk (
  .clk(clk), .rst(rst),
  .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_kind(in_ch.kind),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_t0(out_ch.thruster_0)
);

[verif/fapm_checker.sv]
// Checker for the thruster mixer: predicts thruster commands and compares result items.
`timescale 1ns / 1ps

module fapm_checker (
  input  logic                          clk,
  input  logic                          rst,
  fapm_in_if                            in_mon,
  fapm_out_if                           out_mon,
  input  logic                          cfg_we,
  input  logic [fapm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fapm_pkg::GAINS_W-1:0]  cfg_data,
  output int                            fail_count,
  output int                            pending_cmds
);
  import fapm_pkg::*;

  localparam int  IFRAC = 16;
  localparam int  OFRAC = IFRAC + 6;
  localparam longint ILIM = (255 * (64'sd1 <<< IFRAC) + 50) / 100;

  typedef logic [5:0][CMD_W-1:0] cmd_set_t;

  cmd_set_t       expected_cmds[$];
  logic [GAINS_W-1:0] gain_regs[4];
  longint         integ[4];
  longint         prev_err[4];
  longint         base[4];
  longint         yaw_tgt;
  longint         depth_tgt;
  longint         last_depth;

  // Degrees (1/64) to radians with the internal fraction, rounded half away from zero.
  function automatic longint deg_to_rad(longint ang);
    longint mag;
    longint r;
    mag = (ang < 0) ? -ang : ang;
    r = (mag * DEG2RAD_Q30 + (64'sd1 <<< 19)) >>> 20;
    return (ang < 0) ? -r : r;
  endfunction

  // One PID update on an axis; returns the term with gain fraction added.
  function automatic longint pid_term(int ax, longint err);
    longint kp, ki, kd, s, diff;
    kp = longint'($signed(gain_regs[ax][15:0]));
    ki = longint'($signed(gain_regs[ax][31:16]));
    kd = longint'($signed(gain_regs[ax][47:32]));
    diff = err - prev_err[ax];
    s = integ[ax] + err;
    if (s > ILIM) s = ILIM;
    else if (s < -ILIM) s = -ILIM;
    integ[ax] = s;
    prev_err[ax] = err;
    return kp * err + ki * s + kd * diff;
  endfunction

  // Deadband offset, truncation toward zero and 16-bit saturation.
  function automatic logic [CMD_W-1:0] to_cmd(longint f);
    longint one, t;
    one = 64'sd1 <<< OFRAC;
    if (f >= 0 && f < 1530 * one) f = f + 30 * one;
    else if (f < 0 && f > -1530 * one) f = f - 30 * one;
    t = (f >= 0) ? (f >>> OFRAC) : -((-f) >>> OFRAC);
    if (t > 32767) t = 32767;
    else if (t < -32768) t = -32768;
    return t[CMD_W-1:0];
  endfunction

  task automatic apply_key(logic [KEY_W_BITS-1:0] k);
    case (k)
      KEY_FWD: begin
        base[TH_LEFT] = 1600; base[TH_RIGHT] = 1600;
      end
      KEY_BACK: begin
        base[TH_LEFT] = 1400; base[TH_RIGHT] = 1400;
      end
      KEY_LEFT: begin
        yaw_tgt--;
        if (yaw_tgt < -180) yaw_tgt = 180;
      end
      KEY_RIGHT: begin
        yaw_tgt++;
        if (yaw_tgt > 180) yaw_tgt = -180;
      end
      KEY_SWAYL: base[TH_SWAY] = 1400;
      KEY_SWAYR: base[TH_SWAY] = 1600;
      KEY_DOWN: begin
        base[TH_HEAVE] = 1650; depth_tgt = last_depth;
      end
      KEY_UP: begin
        base[TH_HEAVE] = 1500; depth_tgt = last_depth;
      end
      KEY_STOP: begin
        base[TH_LEFT] = 1500; base[TH_RIGHT] = 1500; base[TH_SWAY] = 1500;
      end
      default: ;
    endcase
  endtask

  task automatic predict_cmds(longint roll, longint pitch, longint yaw, longint depth);
    longint ione, oone, err, br, bp, by, bd, hv;
    cmd_set_t c;
    ione = 64'sd1 <<< IFRAC;
    oone = 64'sd1 <<< OFRAC;
    last_depth = depth;
    br = pid_term(AX_ROLL, -deg_to_rad(roll));
    bp = pid_term(AX_PITCH, -deg_to_rad(pitch));
    // Yaw error wraps by one turn at most.
    err = yaw_tgt * ione - yaw * (64'sd1 <<< (IFRAC - 6));
    if (err > 180 * ione) err = err - 360 * ione;
    else if (err < -180 * ione) err = err + 360 * ione;
    by = pid_term(AX_YAW, err);
    bd = pid_term(AX_DEPTH, (depth_tgt - depth) * (64'sd1 <<< (IFRAC - 4)));
    hv = base[TH_HEAVE] * oone + bd;
    c[0] = to_cmd(hv - bp - br);
    c[1] = to_cmd(hv - bp + br);
    c[2] = to_cmd(hv + 2 * bp);
    c[3] = to_cmd(base[TH_LEFT] * oone + by);
    c[4] = to_cmd(base[TH_RIGHT] * oone - by);
    c[5] = to_cmd(base[TH_SWAY] * oone);
    expected_cmds = {expected_cmds, c};
  endtask

  always @(posedge clk) begin
    cmd_set_t got;
    cmd_set_t want;
    int errs;
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        gain_regs[i] = '0; integ[i] = 0; prev_err[i] = 0; base[i] = 1500;
      end
      yaw_tgt = 0;
      depth_tgt = 13392;
      last_depth = 0;
      expected_cmds.delete();
      fail_count <= 0;
    end else begin
      errs = 0;
      if (cfg_we) gain_regs[cfg_index] = cfg_data;
      // Result items are checked before this edge's input item is predicted.
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.thruster_5, out_mon.thruster_4, out_mon.thruster_3,
               out_mon.thruster_2, out_mon.thruster_1, out_mon.thruster_0};
        if (expected_cmds.size() == 0) begin
          $display("%0t: unexpected result item, got %h", $time, got);
          errs++;
        end else begin
          want = expected_cmds.pop_front();
          for (int i = 0; i < 6; i++) begin
            if (got[i] !== want[i]) begin
              $display("%0t: thruster_%0d expected %0d actual %0d", $time, i,
                       $signed(want[i]), $signed(got[i]));
              errs++;
            end
          end
        end
      end
      if (errs != 0) fail_count <= fail_count + errs;
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.kind == KIND_KEY) apply_key(in_mon.key_code);
        else predict_cmds(longint'(in_mon.roll_angle), longint'(in_mon.pitch_angle),
                          longint'(in_mon.yaw_angle), longint'({1'b0, in_mon.depth_reading}));
      end
    end
    pending_cmds <= expected_cmds.size();
  end

endmodule

[verif/testbench.sv]
// Testbench top: drives sensor and key items and gain writes, then gives the verdict.
`timescale 1ns / 1ps

module testbench;
  import fapm_pkg::*;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [GAINS_W-1:0] cfg_data;
  logic quiet;
  int fail_count;
  int pending_cmds;

  fapm_in_if in_ch ();
  fapm_out_if out_ch ();

  four_axis_pid_thruster_mixer dut (
    .clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  fapm_checker chk (
    .clk(clk), .rst(rst), .in_mon(in_ch), .out_mon(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_cmds(pending_cmds)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver stalls at random unless a quiet stretch is running.
  always @(negedge clk) begin
    out_ch.ready <= quiet || ($urandom_range(0, 99) >= 37);
  end

  // Present one item and hold it until accepted.
  task automatic send_item(logic kind, logic [ANGLE_W-1:0] r, logic [ANGLE_W-1:0] p,
                           logic [ANGLE_W-1:0] y, logic [DEPTH_W-1:0] d,
                           logic [KEY_W_BITS-1:0] k);
    while (!quiet && $urandom_range(0, 99) < 37) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.kind = kind;
    in_ch.roll_angle = r;
    in_ch.pitch_angle = p;
    in_ch.yaw_angle = y;
    in_ch.depth_reading = d;
    in_ch.key_code = k;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic sensor(int r, int p, int y, int d);
    send_item(KIND_SENSOR, r[ANGLE_W-1:0], p[ANGLE_W-1:0], y[ANGLE_W-1:0], d[DEPTH_W-1:0],
              KEY_W_BITS'($urandom_range(0, 15)));
  endtask

  task automatic key(logic [KEY_W_BITS-1:0] k);
    send_item(KIND_KEY, ANGLE_W'($urandom), ANGLE_W'($urandom), ANGLE_W'($urandom),
              DEPTH_W'($urandom), k);
  endtask

  function automatic int rand_angle();
    if ($urandom_range(0, 9) == 0) return int'($signed(15'($urandom)));
    return int'($urandom_range(0, 23040)) - 11520;
  endfunction

  // Drain, let the block settle, then load all four gain registers.
  task automatic load_gains(logic [GAINS_W-1:0] g0, logic [GAINS_W-1:0] g1,
                            logic [GAINS_W-1:0] g2, logic [GAINS_W-1:0] g3);
    logic [GAINS_W-1:0] g[4];
    g = '{g0, g1, g2, g3};
    while (pending_cmds != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we = 1'b1;
      cfg_index = i[CFG_IDX_W-1:0];
      cfg_data = g[i];
      @(negedge clk);
    end
    cfg_we = 1'b0;
  endtask

  function automatic logic [GAINS_W-1:0] small_gains();
    logic [GAINS_W-1:0] v;
    for (int i = 0; i < 3; i++) v[16*i +: 16] = 16'($signed($urandom_range(0, 512)) - 256);
    return v;
  endfunction

  task automatic random_items(int n);
    int burst;
    logic [KEY_W_BITS-1:0] k;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 75) begin
        sensor(rand_angle(), rand_angle(), rand_angle(), int'($urandom_range(0, 65535)));
      end else if ($urandom_range(0, 19) == 0) begin
        // A run of up to 200 yaw nudges can carry the setpoint around its wrap.
        burst = int'($urandom_range(1, 200));
        k = $urandom_range(0, 1) ? KEY_LEFT : KEY_RIGHT;
        repeat (burst) key(k);
        i += burst;
      end else begin
        key(KEY_W_BITS'($urandom_range(0, 15)));
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    quiet = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.kind = KIND_SENSOR;
    in_ch.roll_angle = '0;
    in_ch.pitch_angle = '0;
    in_ch.yaw_angle = '0;
    in_ch.depth_reading = '0;
    in_ch.key_code = '0;
    repeat (4) @(negedge clk);
    rst = 1'b0;

    // Directed: depth capture before any sensor item, with zero gains.
    key(KEY_DOWN);
    sensor(0, 0, 0, 0);
    sensor(11520, -11520, 11520, 65535);
    sensor(-16384, 16383, -16384, 0);
    for (int k = 0; k < 16; k++) key(k[KEY_W_BITS-1:0]);
    load_gains(48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF, 48'h7FFF_7FFF_7FFF,
               48'h7FFF_7FFF_7FFF);
    sensor(11520, 11520, -11520, 65535);
    sensor(-11520, -11520, 11520, 0);
    key(KEY_UP);
    sensor(1, -1, 64, 13392);

    // Random phases across several gain settings.
    load_gains(48'h8000_8000_8000, 48'h8000_8000_8000, 48'h8000_8000_8000,
               48'h8000_8000_8000);
    random_items(200);
    load_gains(small_gains(), small_gains(), small_gains(), small_gains());
    quiet = 1'b1;
    random_items(250);
    quiet = 1'b0;
    load_gains(GAINS_W'({$urandom, $urandom}), GAINS_W'({$urandom, $urandom}),
               GAINS_W'({$urandom, $urandom}), GAINS_W'({$urandom, $urandom}));
    random_items(200);
    // The sender holds off until every command has come back.
    while (pending_cmds != 0) @(negedge clk);
    random_items(100);
    load_gains(small_gains(), small_gains(), small_gains(), small_gains());
    random_items(300);
    load_gains('0, '0, '0, '0);
    random_items(150);
    load_gains(small_gains(), 48'h7FFF_7FFF_7FFF, 48'h8000_8000_8000, small_gains());
    random_items(230);

    while (pending_cmds != 0) @(negedge clk);
    repeat (40) @(negedge clk);
    if (fail_count == 0 && pending_cmds == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #8ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule
